[src/bhed_pkg.sv]
package bhed_pkg;

   localparam int unsigned COUNT_WIDTH_DEFAULT = 16;
   localparam int unsigned THRESHOLD_WIDTH = 16;
   localparam int unsigned CSR_DATA_WIDTH = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned PHASE_WIDTH = 2;
   localparam int unsigned EVENT_CODE_WIDTH = 3;

   typedef enum logic [PHASE_WIDTH-1:0] {
      PH_IDLE = 2'd0,
      PH_PRESSED = 2'd1,
      PH_KEEPING = 2'd2,
      PH_LONG = 2'd3
   } phase_type;

   typedef enum logic [EVENT_CODE_WIDTH-1:0] {
      EV_SHORT = 3'd0,
      EV_KEEP = 3'd1,
      EV_LONG = 3'd2,
      EV_REL_KEEP = 3'd3,
      EV_REL_LONG = 3'd4
   } event_code_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ACTIVE_LEVEL = 2'd0,
      CSR_PRESS_THRESHOLD = 2'd1,
      CSR_KEEP_THRESHOLD = 2'd2,
      CSR_LONG_KEEP_THRESHOLD = 2'd3
   } csr_index_type;

   localparam logic RESET_ACTIVE_LEVEL = 1'b0;
   localparam logic [THRESHOLD_WIDTH-1:0] RESET_PRESS_THRESHOLD = 16'd10;
   localparam logic [THRESHOLD_WIDTH-1:0] RESET_KEEP_THRESHOLD = 16'd100;
   localparam logic [THRESHOLD_WIDTH-1:0] RESET_LONG_KEEP_THRESHOLD = 16'd500;

endpackage

[src/bhed_if.sv]
interface bhed_req_if;
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink (input valid, input pin_level, output ready);
endinterface

interface bhed_rsp_if;
   logic valid;
   logic ready;
   logic [bhed_pkg::PHASE_WIDTH-1:0] phase;
   logic event_valid;
   logic [bhed_pkg::EVENT_CODE_WIDTH-1:0] event_code;

   modport source (output valid, output phase, output event_valid, output event_code,
                   input ready);
   modport sink (input valid, input phase, input event_valid, input event_code,
                 output ready);
endinterface

[src/button_hold_event_detector.sv]
// Button hold event detector. Each transaction on req_ch carries one sampled pin level
// (one timer tick) and produces exactly one transaction on rsp_ch with the phase after
// that tick, an event flag and an event code. One tick is taken per clock cycle while no
// result waits on a stalled rsp_ch; the result is registered in the output register when
// the tick is accepted, and a new tick is accepted in the same cycle a waiting result is
// taken. The consecutive-active counter is COUNT_WIDTH bits wide and saturates. The user
// must write thresholds and the active pin level through the csr_ port only while no tick
// is in flight, which the block does not enforce; use one instance per button.
module button_hold_event_detector #(
   parameter int unsigned COUNT_WIDTH = bhed_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   bhed_req_if.sink req_ch,
   bhed_rsp_if.source rsp_ch,
   input  logic csr_we,
   input  logic [bhed_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bhed_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam int unsigned THR_W = bhed_pkg::THRESHOLD_WIDTH;
   localparam int unsigned CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic active_level_ff;
   logic [THR_W-1:0] press_threshold_ff;
   logic [THR_W-1:0] keep_threshold_ff;
   logic [THR_W-1:0] long_keep_threshold_ff;

   logic [COUNT_WIDTH-1:0] active_count_ff, active_count_in;
   bhed_pkg::phase_type hold_phase_ff, hold_phase_in;

   logic rsp_valid_ff;
   bhed_pkg::phase_type rsp_phase_ff;
   logic rsp_event_valid_ff, rsp_event_valid_in;
   bhed_pkg::event_code_type rsp_event_code_ff, rsp_event_code_in;

   logic req_accept;
   logic pin_active;
   logic [CMP_W-1:0] count_ext;
   logic press_hit, keep_hit, long_hit;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept = req_ch.valid && req_ch.ready;
   assign pin_active = (req_ch.pin_level == active_level_ff);

   always_comb begin
      if (pin_active) begin
         if (active_count_ff != COUNT_MAX) begin
            active_count_in = active_count_ff + COUNT_WIDTH'(1);
         end else begin
            active_count_in = active_count_ff;
         end
      end else begin
         active_count_in = '0;
      end
   end

   assign count_ext = CMP_W'(active_count_in);
   assign press_hit = count_ext >= CMP_W'(press_threshold_ff);
   assign keep_hit = count_ext >= CMP_W'(keep_threshold_ff);
   assign long_hit = count_ext >= CMP_W'(long_keep_threshold_ff);

   always_comb begin
      hold_phase_in = hold_phase_ff;
      rsp_event_valid_in = 1'b0;
      rsp_event_code_in = bhed_pkg::EV_SHORT;
      priority if (hold_phase_ff == bhed_pkg::PH_IDLE && press_hit) begin
         hold_phase_in = bhed_pkg::PH_PRESSED;
      end else if (hold_phase_ff == bhed_pkg::PH_PRESSED && keep_hit) begin
         hold_phase_in = bhed_pkg::PH_KEEPING;
         rsp_event_valid_in = 1'b1;
         rsp_event_code_in = bhed_pkg::EV_KEEP;
      end else if (hold_phase_ff == bhed_pkg::PH_KEEPING && long_hit) begin
         hold_phase_in = bhed_pkg::PH_LONG;
         rsp_event_valid_in = 1'b1;
         rsp_event_code_in = bhed_pkg::EV_LONG;
      end else if (active_count_in == '0) begin
         hold_phase_in = bhed_pkg::PH_IDLE;
         unique case (hold_phase_ff)
            bhed_pkg::PH_LONG: begin
               rsp_event_valid_in = 1'b1;
               rsp_event_code_in = bhed_pkg::EV_REL_LONG;
            end
            bhed_pkg::PH_KEEPING: begin
               rsp_event_valid_in = 1'b1;
               rsp_event_code_in = bhed_pkg::EV_REL_KEEP;
            end
            bhed_pkg::PH_PRESSED: begin
               rsp_event_valid_in = 1'b1;
               rsp_event_code_in = bhed_pkg::EV_SHORT;
            end
            bhed_pkg::PH_IDLE: begin
               rsp_event_valid_in = 1'b0;
            end
            default: begin
               rsp_event_valid_in = 1'b0;
            end
         endcase
      end else begin
         hold_phase_in = hold_phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff <= bhed_pkg::RESET_ACTIVE_LEVEL;
         press_threshold_ff <= bhed_pkg::RESET_PRESS_THRESHOLD;
         keep_threshold_ff <= bhed_pkg::RESET_KEEP_THRESHOLD;
         long_keep_threshold_ff <= bhed_pkg::RESET_LONG_KEEP_THRESHOLD;
      end else if (csr_we) begin
         unique case (bhed_pkg::csr_index_type'(csr_index))
            bhed_pkg::CSR_ACTIVE_LEVEL: active_level_ff <= csr_wdata[0];
            bhed_pkg::CSR_PRESS_THRESHOLD: press_threshold_ff <= csr_wdata[THR_W-1:0];
            bhed_pkg::CSR_KEEP_THRESHOLD: keep_threshold_ff <= csr_wdata[THR_W-1:0];
            bhed_pkg::CSR_LONG_KEEP_THRESHOLD: long_keep_threshold_ff <= csr_wdata[THR_W-1:0];
            default: active_level_ff <= active_level_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_count_ff <= '0;
         hold_phase_ff <= bhed_pkg::PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            active_count_ff <= active_count_in;
            hold_phase_ff <= hold_phase_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_phase_ff <= hold_phase_in;
         rsp_event_valid_ff <= rsp_event_valid_in;
         rsp_event_code_ff <= rsp_event_code_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.phase = rsp_phase_ff;
   assign rsp_ch.event_valid = rsp_event_valid_ff;
   assign rsp_ch.event_code = rsp_event_code_ff;

   a_no_event_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_event_valid_ff) |-> (rsp_event_code_ff == bhed_pkg::EV_SHORT))
      else $error("Result without an event carries a nonzero event code.");

   a_release_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_event_valid_ff
       && (rsp_event_code_ff == bhed_pkg::EV_SHORT
           || rsp_event_code_ff == bhed_pkg::EV_REL_KEEP
           || rsp_event_code_ff == bhed_pkg::EV_REL_LONG))
      |-> (rsp_phase_ff == bhed_pkg::PH_IDLE && hold_phase_ff == bhed_pkg::PH_IDLE))
      else $error("Release event reported without a return to idle.");

   a_hold_event_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_event_valid_ff && rsp_event_code_ff == bhed_pkg::EV_LONG)
      |-> (rsp_phase_ff == bhed_pkg::PH_LONG))
      else $error("Long keeping event reported outside the long keeping phase.");

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      (req_accept && pin_active && active_count_ff == COUNT_MAX)
      |=> (active_count_ff == COUNT_MAX))
      else $error("Active tick counter wrapped past its maximum.");

endmodule

[dv/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      bhed_pkg::phase_type phase;
      logic event_valid;
      bhed_pkg::event_code_type event_code;
   } tick_report_type;

   typedef struct packed {
      bit setup;
      bit pin;
      bit typed;
      tick_report_type want;
      bit level;
      bit [bhed_pkg::THRESHOLD_WIDTH-1:0] press;
      bit [bhed_pkg::THRESHOLD_WIDTH-1:0] keep;
      bit [bhed_pkg::THRESHOLD_WIDTH-1:0] long_keep;
   } script_row_type;

   localparam tick_report_type QUIET_IDLE = '{bhed_pkg::PH_IDLE, 1'b0, bhed_pkg::EV_SHORT};
   localparam bit [bhed_pkg::THRESHOLD_WIDTH-1:0] THRESHOLD_MAX = '1;

   // The first rows run at the reset thresholds, the rest at tiny and then zero thresholds.
   localparam script_row_type DIRECTED_SCRIPT [21] = '{
      '{1'b0, 1'b1, 1'b1, QUIET_IDLE, 1'b0, 16'd0, 16'd0, 16'd0},
      '{1'b0, 1'b0, 1'b1, QUIET_IDLE, 1'b0, 16'd0, 16'd0, 16'd0},
      '{1'b0, 1'b1, 1'b1, QUIET_IDLE, 1'b0, 16'd0, 16'd0, 16'd0},
      '{1'b1, 1'b0, 1'b0, QUIET_IDLE, 1'b1, 16'd1, 16'd2, 16'd3},
      '{1'b0, 1'b1, 1'b0, QUIET_IDLE, 1'b0, 16'd0, 16'd0, 16'd0},
      '{1'b0, 1'b0, 1'b0, QUIET_IDLE, 1'b0, 16'd0, 16'd0, 16'd0},
      '{1'b0, 1'b1, 1'b0, QUIET_IDLE, 1'b0, 16'd0, 16'd0, 16'd0},
      '{1'b0, 1'b1, 1'b0, QUIET_IDLE, 1'b0, 16'd0, 16'd0, 16'd0},
      '{1'b0, 1'b1, 1'b0, QUIET_IDLE, 1'b0, 16'd0, 16'd0, 16'd0},
      '{1'b0, 1'b1, 1'b0, QUIET_IDLE, 1'b0, 16'd0, 16'd0, 16'd0},
      '{1'b0, 1'b0, 1'b0, QUIET_IDLE, 1'b0, 16'd0, 16'd0, 16'd0},
      '{1'b0, 1'b1, 1'b0, QUIET_IDLE, 1'b0, 16'd0, 16'd0, 16'd0},
      '{1'b0, 1'b1, 1'b0, QUIET_IDLE, 1'b0, 16'd0, 16'd0, 16'd0},
      '{1'b0, 1'b0, 1'b0, QUIET_IDLE, 1'b0, 16'd0, 16'd0, 16'd0},
      '{1'b1, 1'b0, 1'b0, QUIET_IDLE, 1'b0, 16'd0, 16'd0, 16'd0},
      '{1'b0, 1'b1, 1'b0, QUIET_IDLE, 1'b0, 16'd0, 16'd0, 16'd0},
      '{1'b0, 1'b1, 1'b0, QUIET_IDLE, 1'b0, 16'd0, 16'd0, 16'd0},
      '{1'b0, 1'b1, 1'b0, QUIET_IDLE, 1'b0, 16'd0, 16'd0, 16'd0},
      '{1'b0, 1'b1, 1'b0, QUIET_IDLE, 1'b0, 16'd0, 16'd0, 16'd0},
      '{1'b0, 1'b0, 1'b0, QUIET_IDLE, 1'b0, 16'd0, 16'd0, 16'd0},
      '{1'b0, 1'b1, 1'b0, QUIET_IDLE, 1'b0, 16'd0, 16'd0, 16'd0}
   };

   localparam bhed_pkg::csr_index_type CSR_ORDER [4] = '{
      bhed_pkg::CSR_ACTIVE_LEVEL, bhed_pkg::CSR_PRESS_THRESHOLD,
      bhed_pkg::CSR_KEEP_THRESHOLD, bhed_pkg::CSR_LONG_KEEP_THRESHOLD
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [bhed_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [bhed_pkg::CSR_DATA_WIDTH-1:0] csr_wdata;

   bhed_req_if req_ch ();
   bhed_rsp_if rsp_ch ();

   button_hold_event_detector dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Predictor state and its copy of the control registers.
   bit cfg_level;
   bit [bhed_pkg::THRESHOLD_WIDTH-1:0] cfg_press;
   bit [bhed_pkg::THRESHOLD_WIDTH-1:0] cfg_keep;
   bit [bhed_pkg::THRESHOLD_WIDTH-1:0] cfg_long_keep;
   bit [bhed_pkg::COUNT_WIDTH_DEFAULT-1:0] held_ticks;
   bhed_pkg::phase_type held_phase;

   tick_report_type pending_reports [$];
   int unsigned failures = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned stall_requests = 0;

   always #5 clock = ~clock;

   function automatic tick_report_type advance_button(bit pin);
      tick_report_type report;
      report = QUIET_IDLE;
      if (pin == cfg_level) begin
         if (held_ticks != '1) held_ticks++;
      end else begin
         held_ticks = '0;
      end
      if (held_phase == bhed_pkg::PH_IDLE && held_ticks >= cfg_press) begin
         held_phase = bhed_pkg::PH_PRESSED;
      end else if (held_phase == bhed_pkg::PH_PRESSED && held_ticks >= cfg_keep) begin
         held_phase = bhed_pkg::PH_KEEPING;
         report.event_valid = 1'b1;
         report.event_code = bhed_pkg::EV_KEEP;
      end else if (held_phase == bhed_pkg::PH_KEEPING && held_ticks >= cfg_long_keep) begin
         held_phase = bhed_pkg::PH_LONG;
         report.event_valid = 1'b1;
         report.event_code = bhed_pkg::EV_LONG;
      end else if (held_ticks == '0) begin
         case (held_phase)
            bhed_pkg::PH_LONG: begin
               report.event_valid = 1'b1;
               report.event_code = bhed_pkg::EV_REL_LONG;
            end
            bhed_pkg::PH_KEEPING: begin
               report.event_valid = 1'b1;
               report.event_code = bhed_pkg::EV_REL_KEEP;
            end
            bhed_pkg::PH_PRESSED: begin
               report.event_valid = 1'b1;
               report.event_code = bhed_pkg::EV_SHORT;
            end
            default: begin
            end
         endcase
         held_phase = bhed_pkg::PH_IDLE;
      end
      report.phase = held_phase;
      return report;
   endfunction

   task automatic send_tick(bit pin, bit typed = 1'b0, tick_report_type want = QUIET_IDLE);
      tick_report_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pin_level <= pin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = advance_button(pin);
      pending_reports.push_back(typed ? want : predicted);
   endtask

   task automatic drain_reports();
      req_ch.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic load_setting(bit level, bit [bhed_pkg::THRESHOLD_WIDTH-1:0] press,
                               bit [bhed_pkg::THRESHOLD_WIDTH-1:0] keep,
                               bit [bhed_pkg::THRESHOLD_WIDTH-1:0] long_keep);
      logic [bhed_pkg::CSR_DATA_WIDTH-1:0] values [4];
      values = '{bhed_pkg::CSR_DATA_WIDTH'(level), press, keep, long_keep};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_ORDER[i];
         csr_wdata <= values[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cfg_level = level;
      cfg_press = press;
      cfg_keep = keep;
      cfg_long_keep = long_keep;
   endtask

   // Mostly clean press and release runs around the thresholds, with some random chatter.
   task automatic run_random(int unsigned n_items, int unsigned max_run);
      int unsigned sent;
      int unsigned run_len;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 85) begin
            run_len = ($urandom_range(1) == 0) ? $urandom_range(max_run, 1)
                                               : $urandom_range(max_run / 8 + 1, 1);
            for (int i = 0; i < run_len; i++) send_tick(cfg_level);
            sent += run_len;
            run_len = $urandom_range(4, 1);
            for (int i = 0; i < run_len; i++) send_tick(~cfg_level);
            sent += run_len;
         end else begin
            run_len = $urandom_range(6, 1);
            for (int i = 0; i < run_len; i++) send_tick(1'($urandom_range(1)));
            sent += run_len;
         end
      end
   endtask

   // Receiver: takes results at random, with an occasional long stall, and checks each one.
   always @(posedge clock) begin
      int unsigned stalls_served;
      int unsigned stall_left;
      tick_report_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_reports.size() == 0) begin
               failures++;
               if (failures <= 10) begin
                  $display("%0t: unexpected transaction: phase %0d event %0b code %0d",
                           $time, rsp_ch.phase, rsp_ch.event_valid, rsp_ch.event_code);
               end
            end else begin
               want = pending_reports.pop_front();
               if (rsp_ch.phase !== want.phase || rsp_ch.event_valid !== want.event_valid
                   || rsp_ch.event_code !== want.event_code) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("%0t: expected phase %0d event %0b code %0d, got %0d %0b %0d",
                              $time, want.phase, want.event_valid, want.event_code,
                              rsp_ch.phase, rsp_ch.event_valid, rsp_ch.event_code);
                  end
               end
            end
         end
         if (stalls_served != stall_requests) begin
            stalls_served = stall_requests;
            stall_left = 60;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      #5ms;
      $display("button_hold_event_detector verification failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.pin_level = 1'b0;
      csr_we = 1'b0;
      csr_index = bhed_pkg::CSR_ACTIVE_LEVEL;
      csr_wdata = '0;
      cfg_level = bhed_pkg::RESET_ACTIVE_LEVEL;
      cfg_press = bhed_pkg::RESET_PRESS_THRESHOLD;
      cfg_keep = bhed_pkg::RESET_KEEP_THRESHOLD;
      cfg_long_keep = bhed_pkg::RESET_LONG_KEEP_THRESHOLD;
      held_ticks = '0;
      held_phase = bhed_pkg::PH_IDLE;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 9;
      recv_idle_pct = 73;
      foreach (DIRECTED_SCRIPT[i]) begin
         if (DIRECTED_SCRIPT[i].setup) begin
            drain_reports();
            load_setting(DIRECTED_SCRIPT[i].level, DIRECTED_SCRIPT[i].press,
                         DIRECTED_SCRIPT[i].keep, DIRECTED_SCRIPT[i].long_keep);
         end else begin
            send_tick(DIRECTED_SCRIPT[i].pin, DIRECTED_SCRIPT[i].typed,
                      DIRECTED_SCRIPT[i].want);
         end
      end

      drain_reports();
      load_setting(1'b1, 16'd1, 16'd2, 16'd3);
      stall_requests++;
      run_random(300, 6);
      drain_reports();
      load_setting(1'b0, 16'd0, 16'd0, 16'd0);
      run_random(150, 5);

      send_idle_pct = 73;
      recv_idle_pct = 9;
      drain_reports();
      load_setting(1'b1, 16'd3, 16'd8, 16'd20);
      run_random(300, 26);
      drain_reports();
      load_setting(1'b1, 16'd5, 16'd2, 16'd1);
      run_random(200, 8);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      drain_reports();
      load_setting(1'b0, bhed_pkg::RESET_PRESS_THRESHOLD, bhed_pkg::RESET_KEEP_THRESHOLD,
                   bhed_pkg::RESET_LONG_KEEP_THRESHOLD);
      stall_requests++;
      run_random(750, 560);

      // With all thresholds at their maximum, a short hold never leaves idle.
      drain_reports();
      load_setting(1'b1, THRESHOLD_MAX, THRESHOLD_MAX, THRESHOLD_MAX);
      repeat (40) send_tick(1'b1);
      repeat (3) send_tick(1'b0);

      drain_reports();
      if (failures == 0) begin
         $display("button_hold_event_detector verification clean");
      end else begin
         $display("button_hold_event_detector verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
src/bhed_pkg.sv
src/bhed_if.sv
src/button_hold_event_detector.sv
dv/tb_top.sv
